>>> src/rolling_hash_pattern_matcher_core_defines.svh
// assertion macros for the rolling hash pattern matcher
// used by the top level only, no other dependencies
`ifndef ROLLING_HASH_PATTERN_MATCHER_CORE_DEFINES_SVH
`define ROLLING_HASH_PATTERN_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RHPM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define RHPM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rhpm_pkg.sv
// shared types, codes and modular helper functions for the rolling hash matcher
// no dependencies
package rhpm_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned HASH_W  = 16;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned PAT_W   = 128;
  localparam int unsigned OUT_W   = 40;
  localparam int unsigned CFG_W   = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [1:0]        cfg_idx_t;

  localparam cfg_idx_t CFG_PATTERN_LENGTH = 2'd0;
  localparam cfg_idx_t CFG_HASH_MODULUS   = 2'd1;
  localparam cfg_idx_t CFG_PATTERN_LOW    = 2'd2;
  localparam cfg_idx_t CFG_PATTERN_HIGH   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESTART,
    ST_LATCH,
    ST_REDUCE,
    ST_MUL,
    ST_SUB,
    ST_SHIFT,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic  load;
    hash_t load_val;
    logic  step;
    logic  shift_bit;
    logic  add_en;
    hash_t add_val;
  } lane_ctl_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic step;
  } win_ctl_t;

  // (2*acc + b) mod q, acc < q except the start value one
  function automatic hash_t mod_dbl(hash_t acc, logic b, hash_t q);
    logic [HASH_W:0] s;
    s = {acc, b};
    if (q == 16'd1) return '0;
    if (s >= {1'b0, q}) return 16'(s - {1'b0, q});
    return 16'(s);
  endfunction

  // (a + b) mod q, both below q
  function automatic hash_t mod_add(hash_t a, hash_t b, hash_t q);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, q}) return 16'(s - {1'b0, q});
    return 16'(s);
  endfunction

  // (a - b) mod q, both below q
  function automatic hash_t mod_sub(hash_t a, hash_t b, hash_t q);
    logic [HASH_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else s = {1'b0, a} + {1'b0, q} - {1'b0, b};
    return 16'(s);
  endfunction

endpackage

>>> src/rhpm_mod_lane.sv
// bit-serial modular accumulator lane: one doubling plus optional add per cycle while stepped
// depends on rhpm_pkg
module rhpm_mod_lane (
  input  logic               clk,
  input  rhpm_pkg::hash_t    q,
  input  rhpm_pkg::lane_ctl_t ctl,
  output rhpm_pkg::hash_t    acc
);

  rhpm_pkg::hash_t acc_r;
  rhpm_pkg::hash_t acc_nxt;
  rhpm_pkg::hash_t dbl;

  always_comb begin
    dbl     = rhpm_pkg::mod_dbl(acc_r, ctl.shift_bit, q);
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = ctl.load_val;
    end else if (ctl.step) begin
      acc_nxt = rhpm_pkg::mod_add(dbl, ctl.add_en ? ctl.add_val : '0, q);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

>>> src/rhpm_window.sv
// text window shift line with a byte-serial pattern compare line
// depends on rhpm_pkg
module rhpm_window #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rhpm_pkg::win_ctl_t                 ctl,
  input  logic [7:0]                         text_byte,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]   m_eff,
  input  logic [rhpm_pkg::PAT_W-1:0]         pat_vec,
  input  logic [3:0]                         cnt,
  output logic [7:0]                         old_byte,
  output logic                               cmp_ok
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0] win_r   [MAX_PATTERN];
  logic [7:0] win_nxt [MAX_PATTERN];
  logic [7:0] cmp_r   [MAX_PATTERN];
  logic [7:0] cmp_nxt [MAX_PATTERN];
  logic       ok_r;
  logic       ok_nxt;
  logic       live;
  logic [4:0] pidx;
  logic [7:0] pat_byte;

  // newest byte sits in entry 0; the byte leaving is at m-1
  assign old_byte = win_r[IDX_W'(m_eff - LEN_W'(1))];

  always_comb begin
    // entry i is compared with pattern byte m-1-i
    live     = {1'b0, cnt} < 5'(m_eff);
    pidx     = 5'(m_eff) - 5'd1 - {1'b0, cnt};
    pat_byte = pat_vec[{pidx[3:0], 3'b000} +: 8];
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i];
      cmp_nxt[i] = cmp_r[i];
    end
    ok_nxt = ok_r;
    if (ctl.load) begin
      win_nxt[0] = text_byte;
      cmp_nxt[0] = text_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        win_nxt[i] = ctl.clear ? 8'd0 : win_r[i-1];
        cmp_nxt[i] = ctl.clear ? 8'd0 : win_r[i-1];
      end
      ok_nxt = 1'b1;
    end else if (ctl.step) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        cmp_nxt[i] = cmp_r[i+1];
      end
      cmp_nxt[MAX_PATTERN-1] = 8'd0;
      if (live && (cmp_r[0] != pat_byte)) ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN; i++) win_r[i] <= 8'd0;
    end else begin
      for (int i = 0; i < MAX_PATTERN; i++) win_r[i] <= win_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) cmp_r[i] <= cmp_nxt[i];
    ok_r <= ok_nxt;
  end

  assign cmp_ok = ok_r;

endmodule

>>> src/rolling_hash_pattern_matcher_core.sv
// top level of the rolling hash (rabin-karp) pattern matcher
// depends on rhpm_pkg, rhpm_mod_lane, rhpm_window and the defines header
//
//   channel   | dir | handshake            | payload
//   ----------+-----+----------------------+------------------------------------------
//   in_       | in  | in_tvalid/in_tready  | tdata: text_byte; tuser: new_text
//   out_      | out | out_tvalid/out_tready| tdata: window_full hash_hit found start
//   cfg_      | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (64 bit)
//
// one word runs from accept to result through the sequencer states of the bit-serial lanes:
// reduce the hash and leading power, multiply the leaving byte by that power (skipped
// while the window is not full), subtract it, shift in the new byte, then done; a word
// with new_text first runs the restart sweep and latch states to rebuild pattern hash
// and leading power; synchronous active-low reset; a finished result waits in the output
// register while the next word is already accepted and worked on
`include "rolling_hash_pattern_matcher_core_defines.svh"

module rolling_hash_pattern_matcher_core #(
  parameter int MAX_PATTERN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] new_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] window_full [1] hash_hit [2] found [34:3] match_start
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W = $clog2(8 * MAX_PATTERN) + 1;

  // configuration registers
  logic [4:0]                       len_r;
  rhpm_pkg::hash_t                  mod_r;
  logic [63:0]                      pat_lo_r;
  logic [63:0]                      pat_hi_r;

  // sequencer and per-word state
  rhpm_pkg::st_t                    state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [7:0]                       byte_r, byte_nxt;
  logic [7:0]                       old_r, old_nxt;
  logic                             full_before_r, full_before_nxt;

  // matcher state kept across words
  logic [rhpm_pkg::COUNT_W-1:0]     bseen_r, bseen_nxt, bseen_base;
  rhpm_pkg::hash_t                  text_hash_r, text_hash_nxt;
  rhpm_pkg::hash_t                  phash_r, phash_nxt;
  rhpm_pkg::hash_t                  lead_r, lead_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [rhpm_pkg::OUT_W-1:0]       out_data_r, out_data_nxt;

  logic                             accept;
  logic                             room;
  logic [LEN_W-1:0]                 m_eff;
  rhpm_pkg::hash_t                  q_eff;
  logic [CNT_W-1:0]                 rs_last;
  logic [CNT_W-1:0]                 h_len;
  logic [rhpm_pkg::PAT_W-1:0]       pat_vec;
  logic [3:0]                       rbyte;
  logic                             pat_bit;

  rhpm_pkg::lane_ctl_t              ctl_a, ctl_b, ctl_c;
  rhpm_pkg::hash_t                  acc_a, acc_b, acc_c;
  rhpm_pkg::win_ctl_t               win_ctl;
  logic [7:0]                       win_old;
  logic                             cmp_ok;

  logic                             full_now;
  logic                             hit_now;
  logic [rhpm_pkg::COUNT_W-1:0]     start_now;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == rhpm_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;  // config should only change while idle; the block itself does not enforce it
  assign room       = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // effective length and modulus: zero length acts as one, long ones clamp
  always_comb begin
    if (len_r == 5'd0) m_eff = LEN_W'(1);
    else if (len_r > 5'(MAX_PATTERN)) m_eff = LEN_W'(MAX_PATTERN);
    else m_eff = LEN_W'(len_r);
  end
  assign q_eff = (mod_r == '0) ? 16'd1 : mod_r;

  // restart sweep: 8*m bits of pattern, the power lane doubles for the first 8*(m-1) bits
  assign rs_last = CNT_W'({m_eff, 3'b000}) - CNT_W'(1);
  assign h_len   = CNT_W'({m_eff - LEN_W'(1), 3'b000});
  assign pat_vec = {pat_hi_r, pat_lo_r};
  assign rbyte   = 4'(cnt_r >> 3);
  assign pat_bit = pat_vec[{rbyte, ~cnt_r[2:0]}];

  rhpm_mod_lane lane_a (.clk(clk), .q(q_eff), .ctl(ctl_a), .acc(acc_a));
  rhpm_mod_lane lane_b (.clk(clk), .q(q_eff), .ctl(ctl_b), .acc(acc_b));
  rhpm_mod_lane lane_c (.clk(clk), .q(q_eff), .ctl(ctl_c), .acc(acc_c));

  rhpm_window #(.MAX_PATTERN(MAX_PATTERN)) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .text_byte (in_tdata),
    .m_eff     (m_eff),
    .pat_vec   (pat_vec),
    .cnt       (cnt_r[3:0]),
    .old_byte  (win_old),
    .cmp_ok    (cmp_ok)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rhpm_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = in_tuser ? rhpm_pkg::ST_RESTART : rhpm_pkg::ST_REDUCE;
      end
      rhpm_pkg::ST_RESTART: begin
        if (cnt_r == rs_last) state_nxt = rhpm_pkg::ST_LATCH;
      end
      rhpm_pkg::ST_LATCH: state_nxt = rhpm_pkg::ST_REDUCE;
      rhpm_pkg::ST_REDUCE: begin
        if (cnt_r == CNT_W'(15)) begin
          state_nxt = full_before_r ? rhpm_pkg::ST_MUL : rhpm_pkg::ST_SUB;
        end
      end
      rhpm_pkg::ST_MUL: begin
        if (cnt_r == CNT_W'(7)) state_nxt = rhpm_pkg::ST_SUB;
      end
      rhpm_pkg::ST_SUB: state_nxt = rhpm_pkg::ST_SHIFT;
      rhpm_pkg::ST_SHIFT: begin
        if (cnt_r == CNT_W'(7)) state_nxt = rhpm_pkg::ST_DONE;
      end
      rhpm_pkg::ST_DONE: begin
        if (room) state_nxt = rhpm_pkg::ST_IDLE;
      end
      default: state_nxt = rhpm_pkg::ST_IDLE;
    endcase
  end

  // lane and window controls
  always_comb begin
    ctl_a   = '0;
    ctl_b   = '0;
    ctl_c   = '0;
    win_ctl = '0;
    unique case (state_r)
      rhpm_pkg::ST_IDLE: begin
        if (accept) begin
          // lane a starts the leading power at one on a restart
          ctl_a.load     = 1'b1;
          ctl_a.load_val = in_tuser ? 16'd1 : 16'd0;
          ctl_b.load     = 1'b1;
          ctl_c.load     = 1'b1;
          win_ctl.load   = 1'b1;
          win_ctl.clear  = in_tuser;
        end
      end
      rhpm_pkg::ST_RESTART: begin
        // a: power times 256 per 8 doublings, c: pattern hash msb first
        ctl_a.step      = (cnt_r < h_len);
        ctl_c.step      = 1'b1;
        ctl_c.shift_bit = pat_bit;
      end
      rhpm_pkg::ST_LATCH: begin
        ctl_a.load = 1'b1;
        ctl_c.load = 1'b1;
      end
      rhpm_pkg::ST_REDUCE: begin
        // a: stored hash mod q, b: leading power mod q, window compare alongside
        ctl_a.step      = 1'b1;
        ctl_a.shift_bit = text_hash_r[~cnt_r[3:0]];
        ctl_b.step      = 1'b1;
        ctl_b.shift_bit = lead_r[~cnt_r[3:0]];
        win_ctl.step    = 1'b1;
      end
      rhpm_pkg::ST_MUL: begin
        // c: leaving byte times reduced power, shift and add
        ctl_c.step    = 1'b1;
        ctl_c.add_en  = old_r[~cnt_r[2:0]];
        ctl_c.add_val = acc_b;
      end
      rhpm_pkg::ST_SUB: begin
        ctl_a.load     = 1'b1;
        ctl_a.load_val = rhpm_pkg::mod_sub(acc_a, acc_c, q_eff);
      end
      rhpm_pkg::ST_SHIFT: begin
        // eight doublings make the times 256, byte bits fill in
        ctl_a.step      = 1'b1;
        ctl_a.shift_bit = byte_r[~cnt_r[2:0]];
      end
      rhpm_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // result of the finished word
  always_comb begin
    full_now  = bseen_r >= 32'(m_eff);
    hit_now   = full_now && (acc_a == phash_r);
    start_now = '0;
    if (full_now) begin
      start_now = (bseen_r == rhpm_pkg::COUNT_MAX) ? rhpm_pkg::COUNT_MAX
                                                   : bseen_r - 32'(m_eff);
    end
  end

  // datapath next values
  always_comb begin
    cnt_nxt         = (state_nxt != state_r || state_r == rhpm_pkg::ST_IDLE) ? '0
                                                                              : cnt_r + 1'b1;
    byte_nxt        = byte_r;
    old_nxt         = old_r;
    full_before_nxt = full_before_r;
    bseen_nxt       = bseen_r;
    text_hash_nxt   = text_hash_r;
    phash_nxt       = phash_r;
    lead_nxt        = lead_r;
    bseen_base      = in_tuser ? '0 : bseen_r;
    out_valid_nxt   = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt    = out_data_r;

    if (accept) begin
      byte_nxt        = in_tdata;
      old_nxt         = in_tuser ? 8'd0 : win_old;
      full_before_nxt = bseen_base >= 32'(m_eff);
      bseen_nxt       = (bseen_base == rhpm_pkg::COUNT_MAX) ? bseen_base
                                                            : bseen_base + 1'b1;
      if (in_tuser) text_hash_nxt = '0;
    end

    if (state_r == rhpm_pkg::ST_LATCH) begin
      lead_nxt  = acc_a;
      phash_nxt = acc_c;
    end

    if (state_r == rhpm_pkg::ST_DONE && room) begin
      text_hash_nxt = acc_a;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'd0, start_now, hit_now && cmp_ok, hit_now, full_now};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhpm_pkg::ST_IDLE;
      cnt_r       <= '0;
      bseen_r     <= '0;
      text_hash_r <= '0;
      phash_r     <= '0;
      lead_r      <= 16'd1;
      out_valid_r <= 1'b0;
      len_r       <= 5'd1;
      mod_r       <= 16'd101;
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bseen_r     <= bseen_nxt;
      text_hash_r <= text_hash_nxt;
      phash_r     <= phash_nxt;
      lead_r      <= lead_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rhpm_pkg::CFG_PATTERN_LENGTH: len_r    <= cfg_data[4:0];
          rhpm_pkg::CFG_HASH_MODULUS:   mod_r    <= cfg_data[15:0];
          rhpm_pkg::CFG_PATTERN_LOW:    pat_lo_r <= cfg_data;
          rhpm_pkg::CFG_PATTERN_HIGH:   pat_hi_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // per-word payload, no reset needed
  always_ff @(posedge clk) begin
    byte_r        <= byte_nxt;
    old_r         <= old_nxt;
    full_before_r <= full_before_nxt;
    out_data_r    <= out_data_nxt;
  end

  `RHPM_ASSERT_NXT(a_accept_starts_work, clk, rst_n, accept, state_r != rhpm_pkg::ST_IDLE, "accepted word left the sequencer idle")
  `RHPM_ASSERT_IMP(a_found_needs_hit, clk, rst_n, out_valid_r, !out_data_r[2] || (out_data_r[1] && out_data_r[0]), "found without hash hit or full window")
  `RHPM_ASSERT_IMP(a_hash_reduced, clk, rst_n, state_r == rhpm_pkg::ST_SHIFT, acc_a < q_eff, "working hash not below modulus")
  `RHPM_ASSERT_NXT(a_done_delivers, clk, rst_n, (state_r == rhpm_pkg::ST_DONE) && !out_valid_r, out_valid_r, "finished word not delivered to output register")

endmodule
